// ===== src/srsc_pkg.sv =====
// ----------------------------------------------------------------------------
// srsc_pkg
// Types, constants and helpers shared by the segment reassembler.
// ----------------------------------------------------------------------------
package srsc_pkg;

  localparam int unsigned BufferBytes = 4096;
  localparam logic [16:0] BufferLimit = 17'(BufferBytes);

  localparam logic [15:0] TypeEnd   = 16'h1234;
  localparam logic [15:0] TypeStart = 16'h1235;
  localparam logic [15:0] TypeMore  = 16'h1236;

  localparam logic [15:0] SegLimitRst = 16'd1024;
  localparam logic [12:0] MsgLimitRst = 13'd4096;

  typedef enum logic [1:0] {
    CFG_SEG_LIMIT = 2'd0,
    CFG_MSG_LIMIT = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_MORE      = 3'd0,
    ST_OK        = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_TOO_SHORT = 3'd6
  } status_e;

  // status reported when a segment ends normally
  function automatic status_e end_status(logic [15:0] seg_type, logic [12:0] idx,
                                         logic [31:0] sum, logic [31:0] tail);
    status_e st;
    if (seg_type != TypeEnd) begin
      st = ST_MORE;
    end else if (idx < 13'd4) begin
      st = ST_TOO_SHORT;
    end else if (sum == tail) begin
      st = ST_OK;
    end else begin
      st = ST_MISMATCH;
    end
    return st;
  endfunction

endpackage

// ===== src/segment_reassembler_with_sum_check.sv =====
// ----------------------------------------------------------------------------
// segment_reassembler_with_sum_check
// Parses segment bodies byte by byte, reassembles messages, passes data
// bytes out with their message index and checks the 32-bit additive sum.
// ----------------------------------------------------------------------------
// a result reaches the result register in the cycle after its input transfer
// throughput: one byte per cycle, input stalls while a result waits untaken
// the result register frees when its result transfers or the byte has none
// reset: parser idle, message cleared, segment_limit 1024, message_limit 4096
// no result output until the first input transfer after reset
module segment_reassembler_with_sum_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  body_byte_i,
  input  logic        body_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic [11:0] data_index_o,
  output logic        segment_done_o,
  output logic [2:0]  status_o,
  output logic [12:0] message_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] seg_limit_q;
  logic [12:0] msg_limit_q;

  srsc_pkg::phase_e phase_q, phase_d, phase_cur;
  logic [1:0]  hcnt_q, hcnt_d, hcnt_cur;
  logic [15:0] seg_type_q, seg_type_d;
  logic [15:0] remaining_q, remaining_d;
  logic [12:0] msg_idx_q, msg_idx_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] tail_q, tail_d;

  logic        out_valid_q, out_valid_d;
  logic        data_valid_q, data_valid_d;
  logic [7:0]  data_byte_q, data_byte_d;
  logic [11:0] data_index_q, data_index_d;
  logic        seg_done_q, seg_done_d;
  srsc_pkg::status_e status_q, status_d;
  logic [12:0] msg_len_q, msg_len_d;

  logic        in_fire;
  logic        res_valid;
  logic [15:0] len;
  logic [16:0] lim;
  logic [16:0] total;
  logic        is_start;
  logic        known_type;
  logic [12:0] base_idx;
  logic [31:0] base_sum;
  logic [31:0] base_tail;
  logic [12:0] idx_inc;
  logic [31:0] sum_inc;
  logic [31:0] tail_inc;
  logic [15:0] rem_dec;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_limit_q <= srsc_pkg::SegLimitRst;
      msg_limit_q <= srsc_pkg::MsgLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        srsc_pkg::CFG_SEG_LIMIT: seg_limit_q <= cfg_data_i;
        srsc_pkg::CFG_MSG_LIMIT: msg_limit_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign len        = {body_byte_i, remaining_q[7:0]};
  assign lim        = ({4'd0, msg_limit_q} < srsc_pkg::BufferLimit) ?
                      {4'd0, msg_limit_q} : srsc_pkg::BufferLimit;
  assign is_start   = (seg_type_q == srsc_pkg::TypeStart);
  assign known_type = is_start || (seg_type_q == srsc_pkg::TypeEnd) ||
                      (seg_type_q == srsc_pkg::TypeMore);
  assign base_idx   = is_start ? 13'd0 : msg_idx_q;
  assign base_sum   = is_start ? 32'd0 : sum_q;
  assign base_tail  = is_start ? 32'd0 : tail_q;
  assign total      = {4'd0, base_idx} + {1'b0, len};

  assign idx_inc  = msg_idx_q + 13'd1;
  assign sum_inc  = (msg_idx_q >= 13'd4) ? sum_q + {24'd0, tail_q[7:0]} : sum_q;
  assign tail_inc = {body_byte_i, tail_q[31:8]};
  assign rem_dec  = remaining_q - 16'd1;

  assign phase_cur = body_start_i ? srsc_pkg::PH_HEADER : phase_q;
  assign hcnt_cur  = body_start_i ? 2'd0 : hcnt_q;

  always_comb begin
    phase_d      = phase_cur;
    hcnt_d       = hcnt_cur;
    seg_type_d   = seg_type_q;
    remaining_d  = remaining_q;
    msg_idx_d    = msg_idx_q;
    sum_d        = sum_q;
    tail_d       = tail_q;
    res_valid    = 1'b0;
    data_valid_d = 1'b0;
    data_byte_d  = 8'd0;
    data_index_d = 12'd0;
    seg_done_d   = 1'b0;
    status_d     = srsc_pkg::ST_MORE;
    msg_len_d    = 13'd0;
    case (phase_cur)
      srsc_pkg::PH_HEADER: begin
        hcnt_d = hcnt_cur + 2'd1;
        case (hcnt_cur)
          2'd0: seg_type_d = {8'd0, body_byte_i};
          2'd1: seg_type_d = {body_byte_i, seg_type_q[7:0]};
          2'd2: remaining_d = {8'd0, body_byte_i};
          default: begin
            remaining_d = len;
            hcnt_d      = 2'd0;
            if (len > seg_limit_q || total > lim || !known_type) begin
              res_valid  = 1'b1;
              seg_done_d = 1'b1;
              msg_len_d  = msg_idx_q;
              if (len > seg_limit_q) begin
                status_d = srsc_pkg::ST_TOO_LONG;
              end else if (total > lim) begin
                status_d = srsc_pkg::ST_OVERFLOW;
              end else begin
                status_d = srsc_pkg::ST_UNKNOWN;
              end
              msg_idx_d = 13'd0;
              sum_d     = 32'd0;
              tail_d    = 32'd0;
              phase_d   = srsc_pkg::PH_IDLE;
            end else begin
              msg_idx_d = base_idx;
              sum_d     = base_sum;
              tail_d    = base_tail;
              if (len == 16'd0) begin
                res_valid  = 1'b1;
                seg_done_d = 1'b1;
                msg_len_d  = base_idx;
                status_d   = srsc_pkg::end_status(seg_type_q, base_idx, base_sum, base_tail);
                phase_d    = srsc_pkg::PH_IDLE;
                if (seg_type_q == srsc_pkg::TypeEnd) begin
                  msg_idx_d = 13'd0;
                  sum_d     = 32'd0;
                  tail_d    = 32'd0;
                end
              end else begin
                phase_d = srsc_pkg::PH_DATA;
              end
            end
          end
        endcase
      end
      srsc_pkg::PH_DATA: begin
        res_valid    = 1'b1;
        data_valid_d = 1'b1;
        data_byte_d  = body_byte_i;
        data_index_d = msg_idx_q[11:0];
        msg_idx_d    = idx_inc;
        sum_d        = sum_inc;
        tail_d       = tail_inc;
        remaining_d  = rem_dec;
        if (rem_dec == 16'd0) begin
          seg_done_d = 1'b1;
          msg_len_d  = idx_inc;
          status_d   = srsc_pkg::end_status(seg_type_q, idx_inc, sum_inc, tail_inc);
          phase_d    = srsc_pkg::PH_IDLE;
          if (seg_type_q == srsc_pkg::TypeEnd) begin
            msg_idx_d = 13'd0;
            sum_d     = 32'd0;
            tail_d    = 32'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= srsc_pkg::PH_IDLE;
      hcnt_q      <= 2'd0;
      seg_type_q  <= 16'd0;
      remaining_q <= 16'd0;
      msg_idx_q   <= 13'd0;
      sum_q       <= 32'd0;
      tail_q      <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q     <= phase_d;
        hcnt_q      <= hcnt_d;
        seg_type_q  <= seg_type_d;
        remaining_q <= remaining_d;
        msg_idx_q   <= msg_idx_d;
        sum_q       <= sum_d;
        tail_q      <= tail_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      data_valid_q <= data_valid_d;
      data_byte_q  <= data_byte_d;
      data_index_q <= data_index_d;
      seg_done_q   <= seg_done_d;
      status_q     <= status_d;
      msg_len_q    <= msg_len_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_valid_o     = data_valid_q;
  assign data_byte_o      = data_byte_q;
  assign data_index_o     = data_index_q;
  assign segment_done_o   = seg_done_q;
  assign status_o         = status_q;
  assign message_length_o = msg_len_q;

`ifndef SYNTHESIS
  a_result_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (data_valid_q || seg_done_q))
    else $error("result with neither data nor segment end");

  a_no_end_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !seg_done_q) |-> (status_q == srsc_pkg::ST_MORE && msg_len_q == 13'd0))
    else $error("status or length without segment end");

  a_data_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == srsc_pkg::PH_DATA) |-> (remaining_q != 16'd0))
    else $error("data phase with no bytes remaining");

  a_index_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {4'd0, msg_idx_q} <= srsc_pkg::BufferLimit)
    else $error("message index beyond buffer");

  a_data_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !body_start_i && phase_q == srsc_pkg::PH_DATA) |=> (out_valid_q && data_valid_q))
    else $error("data byte transfer without result");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives segment bodies into the reassembler with random gaps and output
// stalls. A local model of the parser, the message index and the sum check
// predicts every data byte and every segment end, and each result transfer
// is compared field by field in order. Directed header and limit cases come
// first, then random messages under several limit settings.
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [7:0] octet_q_t[$];

  typedef struct {
    logic              data_valid;
    logic [7:0]        data_byte;
    logic [11:0]       data_index;
    logic              segment_done;
    srsc_pkg::status_e status;
    logic [12:0]       message_length;
  } reasm_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  body_byte_i;
  logic        body_start_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        data_valid_o;
  logic [7:0]  data_byte_o;
  logic [11:0] data_index_o;
  logic        segment_done_o;
  logic [2:0]  status_o;
  logic [12:0] message_length_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  // model state
  srsc_pkg::phase_e ph;
  logic [1:0]  hdr_cnt;
  logic [15:0] cur_type;
  logic [15:0] bytes_left;
  logic [12:0] msg_pos;
  logic [31:0] run_sum;
  logic [31:0] tail_word;
  logic [15:0] seg_limit;
  logic [12:0] msg_limit;

  reasm_out_t  pending_results[$];
  octet_q_t    no_data;
  int unsigned error_count = 0;
  int unsigned useful_items = 0;
  int unsigned send_pace = 9;
  int unsigned recv_pace = 9;

  segment_reassembler_with_sum_check u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .body_byte_i      (body_byte_i),
    .body_start_i     (body_start_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_valid_o     (data_valid_o),
    .data_byte_o      (data_byte_o),
    .data_index_o     (data_index_o),
    .segment_done_o   (segment_done_o),
    .status_o         (status_o),
    .message_length_o (message_length_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic clear_message();
    msg_pos = '0;
    run_sum = '0;
    tail_word = '0;
  endtask

  task automatic drop_message(inout reasm_out_t r, input srsc_pkg::status_e st);
    r.segment_done = 1'b1;
    r.status = st;
    r.message_length = msg_pos;
    clear_message();
    ph = srsc_pkg::PH_IDLE;
  endtask

  task automatic finish_segment(inout reasm_out_t r);
    r.segment_done = 1'b1;
    r.message_length = msg_pos;
    ph = srsc_pkg::PH_IDLE;
    if (cur_type != srsc_pkg::TypeEnd) begin
      r.status = srsc_pkg::ST_MORE;
    end else begin
      if (msg_pos < 13'd4) begin
        r.status = srsc_pkg::ST_TOO_SHORT;
      end else if (run_sum == tail_word) begin
        r.status = srsc_pkg::ST_OK;
      end else begin
        r.status = srsc_pkg::ST_MISMATCH;
      end
      clear_message();
    end
  endtask

  task automatic reassemble_byte(input logic [7:0] b, input logic first);
    reasm_out_t  r;
    logic [16:0] lim;
    logic [16:0] reach;
    r.data_valid = 1'b0;
    r.data_byte = '0;
    r.data_index = '0;
    r.segment_done = 1'b0;
    r.status = srsc_pkg::ST_MORE;
    r.message_length = '0;
    if (first) begin
      ph = srsc_pkg::PH_HEADER;
      hdr_cnt = 2'd0;
    end
    if (ph == srsc_pkg::PH_HEADER) begin
      case (hdr_cnt)
        2'd0: cur_type = {8'h00, b};
        2'd1: cur_type[15:8] = b;
        2'd2: bytes_left = {8'h00, b};
        default: begin
          bytes_left[15:8] = b;
          lim = ({4'd0, msg_limit} < srsc_pkg::BufferLimit) ? {4'd0, msg_limit} :
                srsc_pkg::BufferLimit;
          reach = {1'b0, bytes_left} +
                  ((cur_type == srsc_pkg::TypeStart) ? 17'd0 : {4'd0, msg_pos});
          if (bytes_left > seg_limit) begin
            drop_message(r, srsc_pkg::ST_TOO_LONG);
          end else if (reach > lim) begin
            drop_message(r, srsc_pkg::ST_OVERFLOW);
          end else if (cur_type != srsc_pkg::TypeEnd && cur_type != srsc_pkg::TypeStart &&
                       cur_type != srsc_pkg::TypeMore) begin
            drop_message(r, srsc_pkg::ST_UNKNOWN);
          end else begin
            if (cur_type == srsc_pkg::TypeStart) clear_message();
            if (bytes_left == 16'd0) begin
              finish_segment(r);
            end else begin
              ph = srsc_pkg::PH_DATA;
            end
          end
        end
      endcase
      hdr_cnt = hdr_cnt + 2'd1;
    end else if (ph == srsc_pkg::PH_DATA) begin
      r.data_valid = 1'b1;
      r.data_byte = b;
      r.data_index = msg_pos[11:0];
      if (msg_pos >= 13'd4) run_sum = run_sum + {24'd0, tail_word[7:0]};
      tail_word = {b, tail_word[31:8]};
      msg_pos = msg_pos + 13'd1;
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) finish_segment(r);
    end
    if (r.data_valid || r.segment_done) pending_results.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    gap = $urandom_range(0, send_pace);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    body_byte_i  <= b;
    body_start_i <= first;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (first || ph != srsc_pkg::PH_IDLE) useful_items++;
    reassemble_byte(b, first);
  endtask

  task automatic send_segment(input logic [15:0] kind, input logic [15:0] len,
                              input octet_q_t body);
    send_byte(kind[7:0], 1'b1);
    send_byte(kind[15:8], 1'b0);
    send_byte(len[7:0], 1'b0);
    send_byte(len[15:8], 1'b0);
    foreach (body[i]) send_byte(body[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [15:0] seg, input logic [12:0] msg);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= srsc_pkg::CFG_SEG_LIMIT;
    cfg_data_i  <= seg;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    seg_limit = seg;
    cfg_index_i <= srsc_pkg::CFG_MSG_LIMIT;
    cfg_data_i  <= {3'b000, msg};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    msg_limit = msg;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_sum_check();
    send_segment(srsc_pkg::TypeStart, 16'd1, '{8'hFF});
    send_segment(srsc_pkg::TypeEnd, 16'd4, '{8'hFF, 8'h00, 8'h00, 8'h00});
    // nothing ahead of the tail, so a nonzero tail mismatches
    send_segment(srsc_pkg::TypeEnd, 16'd4, '{8'h01, 8'h00, 8'h00, 8'h00});
  endtask

  task automatic test_header_cases();
    send_segment(srsc_pkg::TypeMore, 16'd0, no_data);
    send_segment(srsc_pkg::TypeEnd, 16'd0, no_data);
    send_segment(16'hFFFF, 16'd0, no_data);
    send_segment(srsc_pkg::TypeEnd, 16'hFFFF, no_data);
  endtask

  task automatic test_cut_and_trailing();
    send_segment(srsc_pkg::TypeStart, 16'd3, '{8'h80});
    send_byte(srsc_pkg::TypeEnd[7:0], 1'b1);
    send_byte(srsc_pkg::TypeEnd[15:8], 1'b0);
    send_segment(srsc_pkg::TypeEnd, 16'd0, no_data);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h55, 1'b0);
  endtask

  task automatic test_limits();
    write_limits(16'hFFFF, 13'd4096);
    send_segment(srsc_pkg::TypeStart, 16'd4097, no_data);
    send_segment(srsc_pkg::TypeStart, 16'd4096, '{8'h12, 8'h34});
    send_segment(srsc_pkg::TypeMore, 16'd4095, no_data);
    write_limits(16'd0, 13'd0);
    send_segment(srsc_pkg::TypeMore, 16'd0, no_data);
    send_segment(srsc_pkg::TypeStart, 16'd1, '{8'h00});
    write_limits(16'd1, 13'd0);
    send_segment(16'h0000, 16'd1, no_data);
    send_segment(srsc_pkg::TypeStart, 16'd1, '{8'h00});
  endtask

  task automatic test_random_traffic();
    int unsigned p, total, nseg, pos, cut, i, s, target, len, k;
    logic [31:0] sum;
    logic [15:0] kind;
    octet_q_t    msg;
    octet_q_t    chunk;
    for (p = 0; p < 10; p++) begin
      case (p)
        0: write_limits(srsc_pkg::SegLimitRst, srsc_pkg::MsgLimitRst);
        1: write_limits(16'd0, 13'd4096);
        2: write_limits(16'hFFFF, 13'd4096);
        3: write_limits(16'd12, 13'd0);
        4: write_limits(16'hFFFF, 13'd30);
        5: write_limits(16'd8, 13'd4096);
        9: write_limits(16'($urandom), 13'($urandom_range(0, 4096)));
        default: write_limits(16'($urandom_range(0, 64)), 13'($urandom_range(0, 120)));
      endcase
      target = useful_items + 190;
      while (useful_items < target) begin
        if ($urandom_range(0, 15) == 0) send_pace = ($urandom_range(0, 2) == 0) ? 0 : 9;
        case ($urandom_range(0, 9))
          7: begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
          end
          8: begin
            case ($urandom_range(0, 3))
              0: kind = 16'($urandom);
              1: kind = {srsc_pkg::TypeEnd[7:0], srsc_pkg::TypeEnd[15:8]};
              2: kind = srsc_pkg::TypeMore + 16'd1;
              default: kind = srsc_pkg::TypeStart ^ (16'd1 << $urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 2))
              0: len = $urandom_range(0, 20);
              1: len = seg_limit + 1;
              default: len = $urandom_range(0, 65535);
            endcase
            k = (len < 6) ? len : 6;
            chunk.delete();
            for (i = 0; i < k; i++) chunk.push_back(8'($urandom));
            send_segment(kind, 16'(len), chunk);
          end
          9: begin
            kind = ($urandom_range(0, 2) == 0) ? srsc_pkg::TypeEnd :
                   ($urandom_range(0, 1) ? srsc_pkg::TypeStart : srsc_pkg::TypeMore);
            if ($urandom_range(0, 2) == 0) begin
              send_byte(kind[7:0], 1'b1);
              repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
            end else begin
              len = $urandom_range(2, 20);
              chunk.delete();
              repeat ($urandom_range(0, len - 1)) chunk.push_back(8'($urandom));
              send_segment(kind, 16'(len), chunk);
            end
          end
          default: begin
            total = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) :
                    ($urandom_range(0, 15) == 0) ? $urandom_range(4, 300) :
                    $urandom_range(4, 40);
            msg.delete();
            for (i = 0; i < total; i++) msg.push_back(8'($urandom));
            if (total >= 4 && $urandom_range(0, 3) != 0) begin
              sum = '0;
              for (i = 0; i + 4 < total; i++) sum = sum + {24'd0, msg[i]};
              for (i = 0; i < 4; i++) msg[total - 4 + i] = sum[8*i +: 8];
            end
            nseg = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 4);
            pos = 0;
            for (s = 0; s < nseg; s++) begin
              cut = (s == nseg - 1) ? total : pos + $urandom_range(0, total - pos);
              if (s == nseg - 1) begin
                kind = srsc_pkg::TypeEnd;
              end else if (s == 0) begin
                kind = ($urandom_range(0, 7) == 0) ? srsc_pkg::TypeMore : srsc_pkg::TypeStart;
              end else begin
                kind = srsc_pkg::TypeMore;
              end
              chunk.delete();
              for (i = pos; i < cut; i++) chunk.push_back(msg[i]);
              send_segment(kind, 16'(cut - pos), chunk);
              pos = cut;
            end
            if ($urandom_range(0, 7) == 0) begin
              repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end
          end
        endcase
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 50 == 0) recv_pace = ($urandom_range(0, 2) == 0) ? 0 : 9;
      stall = $urandom_range(0, recv_pace);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  always @(posedge clk_i) begin : result_check
    reasm_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected transfer: dv %0d byte %h idx %0d done %0d st %0d len %0d",
                   data_valid_o, data_byte_o, data_index_o, segment_done_o, status_o,
                   message_length_o);
        end
      end else begin
        want = pending_results.pop_front();
        if (data_valid_o !== want.data_valid || data_byte_o !== want.data_byte ||
            data_index_o !== want.data_index || segment_done_o !== want.segment_done ||
            status_o !== want.status || message_length_o !== want.message_length) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch exp: dv %0d byte %h idx %0d done %0d st %0d len %0d",
                     want.data_valid, want.data_byte, want.data_index, want.segment_done,
                     want.status, want.message_length);
            $display("         got: dv %0d byte %h idx %0d done %0d st %0d len %0d",
                     data_valid_o, data_byte_o, data_index_o, segment_done_o, status_o,
                     message_length_o);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    body_byte_i  = '0;
    body_start_i = 1'b0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = srsc_pkg::CFG_SEG_LIMIT;
    cfg_data_i   = '0;
    ph           = srsc_pkg::PH_IDLE;
    hdr_cnt      = '0;
    cur_type     = '0;
    bytes_left   = '0;
    seg_limit    = srsc_pkg::SegLimitRst;
    msg_limit    = srsc_pkg::MsgLimitRst;
    clear_message();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_sum_check();
    test_header_cases();
    test_cut_and_trailing();
    test_limits();
    test_random_traffic();
    wait_drained();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
